// File: rtl/core/ffpl_pkg.sv
// shared constants and types of the fern forest posterior learner
package ffpl_pkg;

    localparam int SCORE_W     = 20;
    localparam int WEIGHT_W    = 17;
    localparam int THRESH_W    = 20;
    localparam int FIELD_CODE_W = 13;
    localparam int MAX_TREES   = 10;
    localparam int QBITS       = 17;
    localparam int DIV_CNT_W   = 5;

    localparam int NUM_TREES_DEF  = 10;
    localparam int CODE_BITS_DEF  = 13;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_THR = 1'd1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd327680;

    typedef struct packed {
        logic rd;
        logic start;
        logic step;
        logic wr;
        logic clr;
        logic positive;
    } lane_ctl_t;

endpackage

// File: rtl/core/ffpl_lane.sv
// one tree lane: entry memory, count update and iterative weight divider
module ffpl_lane
    import ffpl_pkg::*;
#(
    parameter int CODE_BITS  = CODE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  lane_ctl_t            ctl,
    input  logic [CODE_BITS-1:0] addr,
    output logic [WEIGHT_W-1:0]  weight
);

    localparam int ENTRY_W = 2 * COUNT_BITS + WEIGHT_W;
    localparam int DEPTH   = 2 ** CODE_BITS;
    localparam int REM_W   = COUNT_BITS + 2;
    localparam int DEN_W   = COUNT_BITS + 1;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [ENTRY_W-1:0] wdata;

    logic [COUNT_BITS-1:0] rd_pos, rd_neg, pos_inc, neg_inc, pos_new, neg_new;
    logic [COUNT_BITS-1:0] pos_reg, neg_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [REM_W-1:0]      rem_reg, diff;
    logic [WEIGHT_W-1:0]   q_reg;
    logic                  cmp;

    assign rd_pos = rdata_reg[ENTRY_W-1 -: COUNT_BITS];
    assign rd_neg = rdata_reg[WEIGHT_W +: COUNT_BITS];
    assign weight = rdata_reg[WEIGHT_W-1:0];

    // saturating increments
    assign pos_inc = (&rd_pos) ? rd_pos : rd_pos + COUNT_BITS'(1);
    assign neg_inc = (&rd_neg) ? rd_neg : rd_neg + COUNT_BITS'(1);
    assign pos_new = ctl.positive ? pos_inc : rd_pos;
    assign neg_new = ctl.positive ? rd_neg : neg_inc;

    assign cmp  = rem_reg >= REM_W'(den_reg);
    assign diff = cmp ? rem_reg - REM_W'(den_reg) : rem_reg;

    assign wdata = ctl.clr ? '0 : {pos_reg, neg_reg, q_reg};

    always_ff @(posedge aclk) begin
        if (ctl.clr || ctl.wr) begin
            mem[addr] <= wdata;
        end
        if (ctl.rd) begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            pos_reg <= pos_new;
            neg_reg <= neg_new;
            den_reg <= DEN_W'(pos_new) + DEN_W'(neg_new);
            rem_reg <= REM_W'(pos_new);
            q_reg   <= '0;
        end else if (ctl.step) begin
            rem_reg <= {diff[REM_W-2:0], 1'b0};
            q_reg   <= {q_reg[WEIGHT_W-2:0], cmp};
        end
    end

endmodule

// File: rtl/core/ffpl_merge.sv
// two-stage registered adder tree over the lane weights
module ffpl_merge
    import ffpl_pkg::*;
#(
    parameter int NUM_TREES = NUM_TREES_DEF
) (
    input  logic                aclk,
    input  logic [WEIGHT_W-1:0] weights [NUM_TREES],
    output logic [SCORE_W-1:0]  score
);

    localparam int NP = (NUM_TREES + 1) / 2;

    logic [WEIGHT_W:0]    pair_reg [NP];
    logic [SCORE_W-1:0]   score_reg;
    logic [SCORE_W-1:0]   score_next;

    for (genvar i = 0; i < NP; i++) begin : g_pair
        if (2 * i + 1 < NUM_TREES) begin : g_two
            always_ff @(posedge aclk) begin
                pair_reg[i] <= (WEIGHT_W+1)'(weights[2*i]) + (WEIGHT_W+1)'(weights[2*i+1]);
            end
        end else begin : g_one
            always_ff @(posedge aclk) begin
                pair_reg[i] <= (WEIGHT_W+1)'(weights[2*i]);
            end
        end
    end

    always_comb begin
        score_next = '0;
        for (int i = 0; i < NP; i++) begin
            score_next = score_next + SCORE_W'(pair_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        score_reg <= score_next;
    end

    assign score = score_reg;

endmodule

// File: rtl/core/fern_forest_posterior_learner.sv
// top level of the fern forest posterior learner
// result: lane entries read, pair sums and score registered in turn, result registered in
//   ST_DEC once the output register is free; a new beat is taken only in ST_IDLE, and a
//   learned item first runs the 17-step quotient loop in each tree lane and a write-back
// reset: synchronous active low; after reset a clearing pass over all 2^CODE_BITS
//   addresses zeroes every entry, s_ready stays low until it completes
module fern_forest_posterior_learner
    import ffpl_pkg::*;
#(
    parameter int NUM_TREES  = NUM_TREES_DEF,
    parameter int CODE_BITS  = CODE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  logic                    s_label,
    input  logic [FIELD_CODE_W-1:0] s_code_0,
    input  logic [FIELD_CODE_W-1:0] s_code_1,
    input  logic [FIELD_CODE_W-1:0] s_code_2,
    input  logic [FIELD_CODE_W-1:0] s_code_3,
    input  logic [FIELD_CODE_W-1:0] s_code_4,
    input  logic [FIELD_CODE_W-1:0] s_code_5,
    input  logic [FIELD_CODE_W-1:0] s_code_6,
    input  logic [FIELD_CODE_W-1:0] s_code_7,
    input  logic [FIELD_CODE_W-1:0] s_code_8,
    input  logic [FIELD_CODE_W-1:0] s_code_9,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SCORE_W-1:0]      m_score,
    output logic                    m_learned,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [THRESH_W-1:0]     cfg_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SUM1  = 3'd3;
    localparam logic [2:0] ST_SUM2  = 3'd4;
    localparam logic [2:0] ST_DEC   = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_WRITE = 3'd7;

    logic [2:0]              st_reg, st_next;
    logic [CODE_BITS-1:0]    clr_reg, clr_next;
    logic [DIV_CNT_W-1:0]    div_reg, div_next;
    logic [THRESH_W-1:0]     pos_thr_reg, neg_thr_reg;
    logic                    action_reg, label_reg;
    logic [CODE_BITS-1:0]    code_reg [NUM_TREES];
    logic [FIELD_CODE_W-1:0] code_in [MAX_TREES];
    logic                    m_valid_reg, m_valid_next;
    logic [SCORE_W-1:0]      m_score_reg;
    logic                    m_learned_reg;
    logic                    learn;
    logic                    out_free;
    logic                    accept;
    lane_ctl_t               ctl;
    logic [WEIGHT_W-1:0]     weights [NUM_TREES];
    logic [SCORE_W-1:0]      score;

    assign code_in = '{s_code_0, s_code_1, s_code_2, s_code_3, s_code_4,
                       s_code_5, s_code_6, s_code_7, s_code_8, s_code_9};

    assign s_ready   = (st_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_score   = m_score_reg;
    assign m_learned = m_learned_reg;

    always_comb begin
        learn = 1'b0;
        if (action_reg) begin
            learn = label_reg ? (THRESH_W'(score) <= pos_thr_reg)
                              : (THRESH_W'(score) >= neg_thr_reg);
        end
    end

    always_comb begin
        ctl          = '0;
        ctl.positive = label_reg;
        st_next      = st_reg;
        clr_next     = clr_reg;
        div_next     = div_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (st_reg)
            ST_CLEAR: begin
                ctl.clr  = 1'b1;
                clr_next = clr_reg + CODE_BITS'(1);
                if (&clr_reg) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    st_next = ST_READ;
                end
            end
            ST_READ: begin
                ctl.rd  = 1'b1;
                st_next = ST_SUM1;
            end
            ST_SUM1: st_next = ST_SUM2;
            ST_SUM2: st_next = ST_DEC;
            ST_DEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (learn) begin
                        ctl.start = 1'b1;
                        div_next  = '0;
                        st_next   = ST_DIV;
                    end else begin
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                ctl.step = 1'b1;
                div_next = div_reg + DIV_CNT_W'(1);
                if (div_reg == DIV_CNT_W'(QBITS - 1)) begin
                    st_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ctl.wr  = 1'b1;
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_CLEAR;
            clr_reg     <= '0;
            div_reg     <= '0;
            m_valid_reg <= 1'b0;
            pos_thr_reg <= THRESH_RESET;
            neg_thr_reg <= THRESH_RESET;
        end else begin
            st_reg      <= st_next;
            clr_reg     <= clr_next;
            div_reg     <= div_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_POS_THR: pos_thr_reg <= cfg_data;
                    CFG_NEG_THR: neg_thr_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= s_action;
            label_reg  <= s_label;
            for (int t = 0; t < NUM_TREES; t++) begin
                code_reg[t] <= CODE_BITS'(code_in[t]);
            end
        end
        if (st_reg == ST_DEC && out_free) begin
            m_score_reg   <= score;
            m_learned_reg <= learn;
        end
    end

    for (genvar t = 0; t < NUM_TREES; t++) begin : g_lane
        ffpl_lane #(
            .CODE_BITS  (CODE_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .aclk   (aclk),
            .ctl    (ctl),
            .addr   ((st_reg == ST_CLEAR) ? clr_reg : code_reg[t]),
            .weight (weights[t])
        );
    end

    ffpl_merge #(
        .NUM_TREES (NUM_TREES)
    ) u_merge (
        .aclk    (aclk),
        .weights (weights),
        .score   (score)
    );

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_CLEAR |-> !m_valid_reg) else $error("result during clearing pass");
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_DIV |-> div_reg < DIV_CNT_W'(QBITS)) else $error("divider overrun");
    a_write_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_WRITE |-> $past(st_reg) == ST_DIV) else $error("write without divide");
`endif

endmodule

// File: tb/sv/tb_fern_forest_posterior_learner.sv
// self-checking testbench of the fern forest posterior learner with a behavioral score predictor
module tb_fern_forest_posterior_learner;
    import ffpl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = NUM_TREES_DEF;
    localparam int CB = CODE_BITS_DEF;
    localparam int ENT = 1 << CB;
    localparam int CNT_MAX = (1 << COUNT_BITS_DEF) - 1;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic action;
        logic label;
        logic [NT*FIELD_CODE_W-1:0] codes;
    } pattern_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic learned;
    } verdict_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic s_action = 0;
    logic s_label = 0;
    logic [FIELD_CODE_W-1:0] s_code [NT];
    logic m_valid;
    logic m_ready = 0;
    logic [SCORE_W-1:0] m_score;
    logic m_learned;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_POS_THR;
    logic [THRESH_W-1:0] cfg_data = 0;

    int unsigned pos_cnt [NT*ENT];
    int unsigned neg_cnt [NT*ENT];
    logic [WEIGHT_W-1:0] wgt [NT*ENT];
    logic [THRESH_W-1:0] pos_thr = THRESH_RESET;
    logic [THRESH_W-1:0] neg_thr = THRESH_RESET;

    pattern_t pending [$];
    verdict_t expected_verdicts [$];
    int errors = 0;
    int cycles = 0;
    bit src_busy_idle = 1;
    bit sink_busy_idle = 1;
    bit sink_hold = 0;
    bit src_pause = 0;
    bit s_ready_seen = 0;

    initial begin
        for (int i = 0; i < NT; i++) s_code[i] = '0;
    end

    fern_forest_posterior_learner u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_action(s_action), .s_label(s_label),
        .s_code_0(s_code[0]), .s_code_1(s_code[1]), .s_code_2(s_code[2]),
        .s_code_3(s_code[3]), .s_code_4(s_code[4]), .s_code_5(s_code[5]),
        .s_code_6(s_code[6]), .s_code_7(s_code[7]), .s_code_8(s_code[8]),
        .s_code_9(s_code[9]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_score(m_score), .m_learned(m_learned),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic verdict_t score_and_learn(pattern_t p);
        verdict_t v;
        int unsigned addr [NT];
        logic [SCORE_W-1:0] sum;
        logic [47:0] q;
        bit learn;
        sum = '0;
        for (int t = 0; t < NT; t++) begin
            addr[t] = t * ENT + (p.codes[t*FIELD_CODE_W +: FIELD_CODE_W] & (ENT - 1));
            sum += wgt[addr[t]];
        end
        learn = p.action && (p.label ? (sum <= pos_thr) : (sum >= neg_thr));
        if (learn) begin
            for (int t = 0; t < NT; t++) begin
                if (p.label) begin
                    if (pos_cnt[addr[t]] < CNT_MAX) pos_cnt[addr[t]]++;
                end else begin
                    if (neg_cnt[addr[t]] < CNT_MAX) neg_cnt[addr[t]]++;
                end
                if (pos_cnt[addr[t]] == 0) begin
                    wgt[addr[t]] = '0;
                end else begin
                    q = (48'(pos_cnt[addr[t]]) << 16) /
                        (48'(pos_cnt[addr[t]]) + 48'(neg_cnt[addr[t]]));
                    wgt[addr[t]] = (q > 65536) ? 17'd65536 : q[WEIGHT_W-1:0];
                end
            end
        end
        v.score = sum;
        v.learned = learn;
        return v;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_fern_forest_posterior_learner failed");
            $finish;
        end
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready_seen) begin
                if (pending.size() > 0 && !src_pause &&
                    !(src_busy_idle && $urandom_range(99) < 20)) begin
                    pattern_t p;
                    p = pending.pop_front();
                    s_valid <= 1;
                    s_action <= p.action;
                    s_label <= p.label;
                    for (int t = 0; t < NT; t++)
                        s_code[t] <= p.codes[t*FIELD_CODE_W +: FIELD_CODE_W];
                end else begin
                    s_valid <= 0;
                end
            end
            m_ready <= !sink_hold && !(sink_busy_idle && $urandom_range(99) < 20);
        end
    end

    always @(posedge aclk) s_ready_seen <= s_valid && s_ready;

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pattern_t p;
                p.action = s_action;
                p.label = s_label;
                for (int t = 0; t < NT; t++)
                    p.codes[t*FIELD_CODE_W +: FIELD_CODE_W] = s_code[t];
                expected_verdicts = {expected_verdicts, score_and_learn(p)};
            end
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result beat score %0d", m_score);
                    errors++;
                end else begin
                    verdict_t e;
                    e = expected_verdicts.pop_front();
                    if (m_score !== e.score) begin
                        $error("score expected %0d actual %0d", e.score, m_score);
                        errors++;
                    end
                    if (m_learned !== e.learned) begin
                        $error("learned expected %0d actual %0d", e.learned, m_learned);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic pattern_t make_pattern(bit act, bit lab, int pool);
        pattern_t p;
        p.action = act;
        p.label = lab;
        for (int t = 0; t < NT; t++)
            p.codes[t*FIELD_CODE_W +: FIELD_CODE_W] =
                (pool == 0) ? FIELD_CODE_W'($urandom) : FIELD_CODE_W'($urandom_range(pool));
        return p;
    endfunction

    task automatic drain();
        wait (pending.size() == 0 && !s_valid);
        wait (expected_verdicts.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_POS_THR) pos_thr = val;
        else pos_thr = pos_thr;
        if (idx == CFG_NEG_THR) neg_thr = val;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    initial begin
        pattern_t p;
        for (int i = 0; i < NT*ENT; i++) begin
            pos_cnt[i] = 0;
            neg_cnt[i] = 0;
            wgt[i] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: extremes of codes, both actions and labels
        for (int k = 0; k < 4; k++) begin
            p.action = k[1];
            p.label = k[0];
            p.codes = '0;
            pending = {pending, p};
            p.codes = '1;
            pending = {pending, p};
        end
        for (int k = 0; k < 6; k++) pending = {pending, make_pattern(1, 1, 3)};
        for (int k = 0; k < 4; k++) pending = {pending, make_pattern(1, 0, 3)};
        pending = {pending, make_pattern(0, 1, 3)};
        drain();

        // repeated learning on one entry per tree
        p.action = 1;
        p.label = 1;
        p.codes = '0;
        write_reg(CFG_POS_THR, 20'hFFFFF);
        for (int k = 0; k < 2; k++) pending = {pending, p};
        drain();

        // random phases over several threshold settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_POS_THR, 20'd0); write_reg(CFG_NEG_THR, 20'd0); end
                1: begin write_reg(CFG_POS_THR, 20'd655360); write_reg(CFG_NEG_THR, 20'd655360); end
                2: begin write_reg(CFG_POS_THR, 20'hFFFFF); write_reg(CFG_NEG_THR, 20'hFFFFF); end
                default: begin
                    write_reg(CFG_POS_THR, THRESH_W'($urandom_range(655360)));
                    write_reg(CFG_NEG_THR, THRESH_W'($urandom_range(655360)));
                end
            endcase
            src_busy_idle = (ph != 3);
            sink_busy_idle = (ph != 3);
            for (int k = 0; k < 250; k++)
                pending = {pending, make_pattern($urandom_range(99) < 75, $urandom_range(1),
                                                 ($urandom_range(9) < 7) ? 15 : 0)};
            if (ph == 4) begin
                sink_hold = 1;
                repeat (600) @(posedge aclk);
                sink_hold = 0;
            end
            if (ph == 5) begin
                wait (pending.size() < 120);
                src_pause = 1;
                wait (expected_verdicts.size() == 0 && !s_valid);
                src_pause = 0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_fern_forest_posterior_learner passed");
        end else begin
            $display("tb_fern_forest_posterior_learner failed");
        end
        $finish;
    end

endmodule

// File: fern_forest_posterior_learner.f
rtl/core/ffpl_pkg.sv
rtl/core/ffpl_lane.sv
rtl/core/ffpl_merge.sv
rtl/core/fern_forest_posterior_learner.sv
tb/sv/tb_fern_forest_posterior_learner.sv
